[sv/climate_relay_controller_macros.svh]
// Assertion macros for the climate relay controller checker.
// Used only by crc_checker.sv; needs nothing else.
`ifndef CLIMATE_RELAY_CONTROLLER_MACROS_SVH
`define CLIMATE_RELAY_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("climate relay controller check failed");

// Next-cycle implication, disabled during reset.
`define CRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("climate relay controller check failed");

`endif

[sv/crc_pkg.sv]
// Shared types and constants of the climate relay controller.
// No dependencies; used by crc_ctrl, climate_relay_controller and crc_checker.
package crc_pkg;

   localparam int TICK_SECONDS_DEF         = 5;
   localparam int DOOR_TIMEOUT_SECONDS_DEF = 900;

   localparam int FAN_W       = 20;
   localparam int DOOR_W      = 10;
   localparam int TEMP_W      = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;
   localparam int SECS_PER_MIN = 60;

   localparam logic [FAN_W-1:0] FAN_MAX          = '1;
   localparam logic [9:0]       HUMID_VENT_LIMIT = 10'd900;
   localparam logic [11:0]      MINUTES_PER_HOUR_HHMM = 12'd100;

   // status bit positions
   localparam int ST_HEAT  = 0;
   localparam int ST_COOL  = 1;
   localparam int ST_HUMID = 2;
   localparam int ST_LIGHT = 3;
   localparam int ST_VENT  = 4;

   // disable mask bit positions
   localparam int DIS_TEMP  = 0;
   localparam int DIS_HUMID = 1;
   localparam int DIS_LIGHT = 2;
   localparam int DIS_VENT  = 3;

   localparam logic [1:0] DOOR_NONE  = 2'd0;
   localparam logic [1:0] DOOR_ENTER = 2'd1;
   localparam logic [1:0] DOOR_LEAVE = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEMP_SETPOINT    = 3'd0,
      REG_TEMP_BAND        = 3'd1,
      REG_HUMID_SETPOINT   = 3'd2,
      REG_HUMID_BAND       = 3'd3,
      REG_LIGHT_START_HHMM = 3'd4,
      REG_LIGHT_STOP_HHMM  = 3'd5,
      REG_FAN_RUN_MINUTES  = 3'd6,
      REG_FAN_IDLE_MINUTES = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [9:0]  temp_setpoint;
      logic [9:0]  temp_band;
      logic [9:0]  humid_setpoint;
      logic [9:0]  humid_band;
      logic [11:0] light_start_hhmm;
      logic [11:0] light_stop_hhmm;
      logic [9:0]  fan_run_minutes;
      logic [9:0]  fan_idle_minutes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      temp_setpoint:    10'd250,
      temp_band:        10'd10,
      humid_setpoint:   10'd950,
      humid_band:       10'd10,
      light_start_hhmm: 12'd600,
      light_stop_hhmm:  12'd1800,
      fan_run_minutes:  10'd15,
      fan_idle_minutes: 10'd105
   };

   typedef struct packed {
      logic [FAN_W-1:0]         fan_cycle_seconds;
      logic signed [TEMP_W-1:0] previous_temp;
      logic [4:0]               status_bits;
      logic                     door_mode;
      logic [DOOR_W-1:0]        door_seconds_left;
   } state_type;

   localparam state_type STATE_RESET = '{
      fan_cycle_seconds: '0,
      previous_temp:     12'sd255,
      status_bits:       '0,
      door_mode:         1'b0,
      door_seconds_left: '0
   };

   // last member sits in the lowest bits
   typedef struct packed {
      logic [1:0]               door_event;
      logic [3:0]               disable_mask;
      logic [5:0]               clock_minute;
      logic [4:0]               clock_hour;
      logic [9:0]               humid_tenths;
      logic signed [TEMP_W-1:0] temp_tenths;
   } item_type;

   typedef struct packed {
      logic [4:0] status_flags;
      logic       door_mode_active;
      logic       vent_relay;
      logic       light_relay;
      logic       humidify_relay;
      logic       cool_relay;
      logic       heat_relay;
   } result_type;

endpackage

[sv/crc_ctrl.sv]
// One control tick of the climate relay controller: next state and relay result.
// Pure combinational logic; depends on crc_pkg.
module crc_ctrl
   import crc_pkg::*;
#(
   parameter int TICK_SECONDS         = TICK_SECONDS_DEF,
   parameter int DOOR_TIMEOUT_SECONDS = DOOR_TIMEOUT_SECONDS_DEF
) (
   input  cfg_type    cfg,
   input  state_type  st,
   input  item_type   item,
   output state_type  st_next,
   output result_type res
);

   localparam logic [FAN_W-1:0]  TICK_FAN  = FAN_W'(TICK_SECONDS);
   localparam logic [DOOR_W-1:0] TICK_DOOR = DOOR_W'(TICK_SECONDS);
   localparam logic [DOOR_W-1:0] DOOR_LOAD = DOOR_W'(DOOR_TIMEOUT_SECONDS);
   localparam logic [FAN_W-1:0]  MIN_SECS  = FAN_W'(SECS_PER_MIN);

   logic [FAN_W-1:0]         run_s;
   logic [FAN_W-1:0]         period_s;
   logic [10:0]              fan_minutes;
   logic [FAN_W-1:0]         fan_v;
   logic [FAN_W:0]           fan_sum;
   logic                     door_mode_v;
   logic [DOOR_W-1:0]        left_v;
   logic [4:0]               status_v;
   logic [11:0]              now_hhmm;
   logic                     dis_temp, dis_humid, dis_light, dis_vent;
   logic [10:0]              humid_hi;
   logic [10:0]              humid_lo_lhs;
   logic signed [TEMP_W:0]   temp_x;
   logic signed [TEMP_W:0]   tset_x;
   logic signed [TEMP_W:0]   thi_x;
   logic signed [TEMP_W:0]   tlo_lhs;
   logic [10:0]              thi_sum;

   assign fan_minutes = {1'b0, cfg.fan_run_minutes} + {1'b0, cfg.fan_idle_minutes};
   assign run_s       = FAN_W'(cfg.fan_run_minutes) * MIN_SECS;
   assign period_s    = FAN_W'(fan_minutes) * MIN_SECS;
   assign now_hhmm    = 12'(item.clock_hour) * MINUTES_PER_HOUR_HHMM + 12'(item.clock_minute);

   assign dis_temp  = item.disable_mask[DIS_TEMP];
   assign dis_humid = item.disable_mask[DIS_HUMID];
   assign dis_light = item.disable_mask[DIS_LIGHT];
   assign dis_vent  = item.disable_mask[DIS_VENT];

   assign humid_hi     = {1'b0, cfg.humid_setpoint} + {1'b0, cfg.humid_band};
   assign humid_lo_lhs = {1'b0, item.humid_tenths} + {1'b0, cfg.humid_band};

   assign thi_sum = {1'b0, cfg.temp_setpoint} + {1'b0, cfg.temp_band};
   assign temp_x  = {item.temp_tenths[TEMP_W-1], item.temp_tenths};
   assign tset_x  = $signed({3'b000, cfg.temp_setpoint});
   assign thi_x   = $signed({2'b00, thi_sum});
   assign tlo_lhs = temp_x + $signed({3'b000, cfg.temp_band});

   always_comb begin
      st_next     = st;
      res         = '0;
      door_mode_v = st.door_mode;
      left_v      = st.door_seconds_left;
      fan_v       = st.fan_cycle_seconds;
      status_v    = st.status_bits;

      if (item.door_event == DOOR_ENTER) begin
         door_mode_v = 1'b1;
         left_v      = DOOR_LOAD;
      end else if (item.door_event == DOOR_LEAVE) begin
         door_mode_v = 1'b0;
      end

      if (door_mode_v) begin
         res.door_mode_active = 1'b1;
         res.light_relay      = 1'b1;
         if (left_v > TICK_DOOR) begin
            left_v = left_v - TICK_DOOR;
         end else begin
            left_v      = '0;
            door_mode_v = 1'b0;
         end
      end else begin
         // fan duty cycle
         if (fan_v < run_s) begin
            status_v[ST_VENT] = !dis_vent;
         end else begin
            if (fan_v >= period_s) begin
               fan_v = fan_v - period_s;
            end
            status_v[ST_VENT] = 1'b0;
         end

         // humidity hysteresis and vent override
         if (item.humid_tenths > cfg.humid_setpoint || dis_humid) begin
            status_v[ST_HUMID] = 1'b0;
         end else if (humid_lo_lhs < {1'b0, cfg.humid_setpoint}) begin
            status_v[ST_HUMID] = 1'b1;
         end
         if (cfg.humid_setpoint > HUMID_VENT_LIMIT &&
             {1'b0, item.humid_tenths} > humid_hi && !dis_vent) begin
            status_v[ST_VENT] = 1'b1;
         end

         // light window
         if (cfg.light_start_hhmm < cfg.light_stop_hhmm) begin
            status_v[ST_LIGHT] = now_hhmm >= cfg.light_start_hhmm &&
                                 now_hhmm < cfg.light_stop_hhmm && !dis_light;
         end else if (cfg.light_start_hhmm > cfg.light_stop_hhmm) begin
            status_v[ST_LIGHT] = !(dis_light || (now_hhmm >= cfg.light_stop_hhmm &&
                                                 now_hhmm < cfg.light_start_hhmm));
         end else begin
            status_v[ST_LIGHT] = 1'b0;
         end

         // temperature with trend
         if (dis_temp) begin
            status_v[ST_HEAT] = 1'b0;
            status_v[ST_COOL] = 1'b0;
         end else if (st.previous_temp > item.temp_tenths) begin
            if (temp_x < tset_x) begin
               status_v[ST_HEAT] = 1'b1;
               status_v[ST_COOL] = 1'b0;
            end
         end else if (st.previous_temp < item.temp_tenths) begin
            if (temp_x > tset_x) begin
               status_v[ST_COOL] = 1'b1;
               status_v[ST_HEAT] = 1'b0;
            end
         end else begin
            if (temp_x > thi_x) begin
               status_v[ST_COOL] = 1'b1;
               status_v[ST_HEAT] = 1'b0;
            end else if (tlo_lhs < tset_x) begin
               status_v[ST_HEAT] = 1'b1;
               status_v[ST_COOL] = 1'b0;
            end else begin
               status_v[ST_HEAT] = 1'b0;
               status_v[ST_COOL] = 1'b0;
            end
         end
         st_next.previous_temp = item.temp_tenths;

         res.heat_relay     = status_v[ST_HEAT];
         res.cool_relay     = !status_v[ST_HEAT] && status_v[ST_COOL];
         res.humidify_relay = status_v[ST_HUMID];
         res.light_relay    = status_v[ST_LIGHT];
         res.vent_relay     = status_v[ST_VENT];
      end

      // advance fan time, saturating
      fan_sum = {1'b0, fan_v} + {1'b0, TICK_FAN};
      fan_v   = fan_sum[FAN_W] ? FAN_MAX : fan_sum[FAN_W-1:0];

      res.status_flags          = status_v;
      st_next.status_bits       = status_v;
      st_next.fan_cycle_seconds = fan_v;
      st_next.door_mode         = door_mode_v;
      st_next.door_seconds_left = left_v;
   end

endmodule

[sv/climate_relay_controller.sv]
// Climate relay controller top level: stream ports, register file, state and result beat.
// Depends on crc_pkg and crc_ctrl.
//
// Every request beat is one control tick and yields exactly one response beat, in the
// cycle after it is taken. The tick is computed combinationally from the request beat, the
// registers and the held state, and lands in the response register; a new beat is taken
// every cycle as long as the response register is empty or is being drained, so the rate
// is one tick per cycle. Register writes take effect at the next clock edge and should be
// made only while no tick is in flight.
module climate_relay_controller
   import crc_pkg::*;
#(
   parameter int TICK_SECONDS         = TICK_SECONDS_DEF,
   parameter int DOOR_TIMEOUT_SECONDS = DOOR_TIMEOUT_SECONDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // temp_tenths[11:0], humid_tenths[21:12], clock_hour[26:22], clock_minute[32:27],
   // disable_mask[36:33], door_event[38:37], zero[39]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // heat_relay[0], cool_relay[1], humidify_relay[2], light_relay[3], vent_relay[4],
   // door_mode_active[5], status_flags[10:6], zero[15:11]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cfg_type                 cfg_ff, cfg_in;
   state_type               state_ff, state_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   state_type               st_next;
   result_type              res;
   item_type                item;
   logic                    accept;

   assign item       = item_type'(req_tdata[$bits(item_type)-1:0]);
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   crc_ctrl #(
      .TICK_SECONDS         (TICK_SECONDS),
      .DOOR_TIMEOUT_SECONDS (DOOR_TIMEOUT_SECONDS)
   ) u_ctrl (
      .cfg     (cfg_ff),
      .st      (state_ff),
      .item    (item),
      .st_next (st_next),
      .res     (res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_TEMP_SETPOINT:    cfg_in.temp_setpoint    = csr_wdata[9:0];
            REG_TEMP_BAND:        cfg_in.temp_band        = csr_wdata[9:0];
            REG_HUMID_SETPOINT:   cfg_in.humid_setpoint   = csr_wdata[9:0];
            REG_HUMID_BAND:       cfg_in.humid_band       = csr_wdata[9:0];
            REG_LIGHT_START_HHMM: cfg_in.light_start_hhmm = csr_wdata[11:0];
            REG_LIGHT_STOP_HHMM:  cfg_in.light_stop_hhmm  = csr_wdata[11:0];
            REG_FAN_RUN_MINUTES:  cfg_in.fan_run_minutes  = csr_wdata[9:0];
            REG_FAN_IDLE_MINUTES: cfg_in.fan_idle_minutes = csr_wdata[9:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = accept ? st_next : state_ff;
      rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);
      rsp_tdata_in  = accept ? RSP_DATA_W'(res) : rsp_tdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         state_ff      <= STATE_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

[sv/crc_checker.sv]
// Port-level checks of the climate relay controller, bound to the top level.
// Depends on crc_pkg and climate_relay_controller_macros.svh.
`include "climate_relay_controller_macros.svh"

module crc_checker
   import crc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `CRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CRC_ASSERT_NEXT(a_beat_yields_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid)
   `CRC_ASSERT_SAME(a_heat_cool_excl, clock, reset, rsp_tvalid, !(rsp_tdata[ST_HEAT] && rsp_tdata[ST_COOL]))
   `CRC_ASSERT_SAME(a_door_light_only, clock, reset, rsp_tvalid && rsp_tdata[5], rsp_tdata[4:0] == 5'b01000)

endmodule

bind climate_relay_controller crc_checker u_crc_checker (.*);

[tb/climate_relay_controller_tb.sv]
// Testbench for climate_relay_controller: drives control ticks and register writes,
// predicts every relay beat and checks it in order. Depends on crc_pkg and the RTL.
module climate_relay_controller_tb
   import crc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int TICK_S       = TICK_SECONDS_DEF;
   localparam int DOOR_S       = DOOR_TIMEOUT_SECONDS_DEF;
   localparam int DRAIN_CYCLES = 4;
   localparam int IDLE_LIMIT   = 5000;
   localparam int PHASE_TICKS  = 100;
   localparam int STALL_AFTER  = 400;
   localparam int STALL_CYCLES = 600;
   localparam logic [1:0] DOOR_UNUSED = 2'd3;

   class relay_scoreboard;
      cfg_type    cfg;
      int         fan_secs;
      int         prior_temp;
      logic [4:0] status;
      bit         door_on;
      int         door_left;
      result_type relays_due[$];
      int         failures;
      int         beats;

      function new();
         cfg        = CFG_RESET;
         fan_secs   = 0;
         prior_temp = 255;
         status     = '0;
         door_on    = 1'b0;
         door_left  = 0;
         failures   = 0;
         beats      = 0;
      endfunction

      function void store_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_TEMP_SETPOINT:    cfg.temp_setpoint    = v[9:0];
            REG_TEMP_BAND:        cfg.temp_band        = v[9:0];
            REG_HUMID_SETPOINT:   cfg.humid_setpoint   = v[9:0];
            REG_HUMID_BAND:       cfg.humid_band       = v[9:0];
            REG_LIGHT_START_HHMM: cfg.light_start_hhmm = v;
            REG_LIGHT_STOP_HHMM:  cfg.light_stop_hhmm  = v;
            REG_FAN_RUN_MINUTES:  cfg.fan_run_minutes  = v[9:0];
            REG_FAN_IDLE_MINUTES: cfg.fan_idle_minutes = v[9:0];
            default: ;
         endcase
      endfunction

      function void advance_fan();
         fan_secs = fan_secs + TICK_S;
         if (fan_secs > int'(FAN_MAX)) fan_secs = int'(FAN_MAX);
      endfunction

      function void note_tick(item_type it);
         int temp, hum, now, run_s, period_s, tset, tband, hset, hband, lstart, lstop, delta;
         bit dis_temp, dis_humid, dis_light, dis_vent;
         result_type exp_r;
         temp      = $signed(it.temp_tenths);
         hum       = int'(it.humid_tenths);
         now       = int'(it.clock_hour) * 100 + int'(it.clock_minute);
         dis_temp  = it.disable_mask[DIS_TEMP];
         dis_humid = it.disable_mask[DIS_HUMID];
         dis_light = it.disable_mask[DIS_LIGHT];
         dis_vent  = it.disable_mask[DIS_VENT];
         exp_r     = '0;

         if (it.door_event == DOOR_ENTER) begin
            door_on   = 1'b1;
            door_left = DOOR_S & 'h3FF;
         end else if (it.door_event == DOOR_LEAVE) begin
            door_on = 1'b0;
         end

         if (door_on) begin
            exp_r.light_relay      = 1'b1;
            exp_r.door_mode_active = 1'b1;
            if (door_left > TICK_S) begin
               door_left = door_left - TICK_S;
            end else begin
               door_left = 0;
               door_on   = 1'b0;
            end
            advance_fan();
         end else begin
            run_s    = int'(cfg.fan_run_minutes) * SECS_PER_MIN;
            period_s = (int'(cfg.fan_run_minutes) + int'(cfg.fan_idle_minutes)) * SECS_PER_MIN;
            tset     = int'(cfg.temp_setpoint);
            tband    = int'(cfg.temp_band);
            hset     = int'(cfg.humid_setpoint);
            hband    = int'(cfg.humid_band);
            lstart   = int'(cfg.light_start_hhmm);
            lstop    = int'(cfg.light_stop_hhmm);

            if (fan_secs < run_s) begin
               status[ST_VENT] = !dis_vent;
            end else begin
               if (fan_secs >= period_s) fan_secs = fan_secs - period_s;
               status[ST_VENT] = 1'b0;
            end
            advance_fan();

            if (hum > hset || dis_humid) status[ST_HUMID] = 1'b0;
            else if (hum < hset - hband) status[ST_HUMID] = 1'b1;
            if (hset > int'(HUMID_VENT_LIMIT) && hum > hset + hband && !dis_vent)
               status[ST_VENT] = 1'b1;

            if (lstart < lstop)
               status[ST_LIGHT] = now >= lstart && now < lstop && !dis_light;
            else if (lstart > lstop)
               status[ST_LIGHT] = !(dis_light || (now >= lstop && now < lstart));
            else
               status[ST_LIGHT] = 1'b0;

            delta = prior_temp - temp;
            if (dis_temp) begin
               status[ST_HEAT] = 1'b0;
               status[ST_COOL] = 1'b0;
            end else if (delta > 0) begin
               if (temp < tset) begin
                  status[ST_HEAT] = 1'b1;
                  status[ST_COOL] = 1'b0;
               end
            end else if (delta < 0) begin
               if (temp > tset) begin
                  status[ST_COOL] = 1'b1;
                  status[ST_HEAT] = 1'b0;
               end
            end else if (temp > tset + tband) begin
               status[ST_COOL] = 1'b1;
               status[ST_HEAT] = 1'b0;
            end else if (temp < tset - tband) begin
               status[ST_HEAT] = 1'b1;
               status[ST_COOL] = 1'b0;
            end else begin
               status[ST_HEAT] = 1'b0;
               status[ST_COOL] = 1'b0;
            end
            prior_temp = temp;

            exp_r.heat_relay     = status[ST_HEAT];
            exp_r.cool_relay     = !status[ST_HEAT] && status[ST_COOL];
            exp_r.humidify_relay = status[ST_HUMID];
            exp_r.light_relay    = status[ST_LIGHT];
            exp_r.vent_relay     = status[ST_VENT];
         end
         exp_r.status_flags = status;
         relays_due.push_back(exp_r);
      endfunction

      function void check_relays(result_type got);
         result_type exp_r;
         bit bad;
         beats++;
         if (relays_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("beat %0d: relay beat with no tick pending, got %011b", beats, got);
            return;
         end
         exp_r = relays_due.pop_front();
         bad = (got.heat_relay !== exp_r.heat_relay) ||
               (got.cool_relay !== exp_r.cool_relay) ||
               (got.humidify_relay !== exp_r.humidify_relay) ||
               (got.light_relay !== exp_r.light_relay) ||
               (got.vent_relay !== exp_r.vent_relay) ||
               (got.door_mode_active !== exp_r.door_mode_active) ||
               (got.status_flags !== exp_r.status_flags);
         if (bad) begin
            failures++;
            if (failures <= 10)
               $display({"beat %0d: exp heat=%0b cool=%0b humid=%0b light=%0b vent=%0b ",
                         "door=%0b flags=%05b | got heat=%0b cool=%0b humid=%0b light=%0b ",
                         "vent=%0b door=%0b flags=%05b"}, beats,
                        exp_r.heat_relay, exp_r.cool_relay, exp_r.humidify_relay,
                        exp_r.light_relay, exp_r.vent_relay, exp_r.door_mode_active,
                        exp_r.status_flags, got.heat_relay, got.cool_relay,
                        got.humidify_relay, got.light_relay, got.vent_relay,
                        got.door_mode_active, got.status_flags);
         end
      endfunction

      function int pending();
         return relays_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   relay_scoreboard sb;
   int  ticks_sent = 0;
   int  prev_sent_temp = 255;
   int  rx_cycle = 0;
   int  rx_hold = 0;
   bit  rx_pressed = 1'b0;
   int  idle_cycles = 0;

   climate_relay_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int pick_gap();
      int r;
      if ((ticks_sent % 200) >= 160) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_tick(input item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(it);
      ticks_sent++;
      prev_sent_temp = $signed(it.temp_tenths);
   endtask

   task automatic send_fields(input int temp, input int hum, input int hh, input int mm,
                              input int mask, input logic [1:0] door);
      item_type it;
      it.temp_tenths  = temp[TEMP_W-1:0];
      it.humid_tenths = hum[9:0];
      it.clock_hour   = hh[4:0];
      it.clock_minute = mm[5:0];
      it.disable_mask = mask[3:0];
      it.door_event   = door;
      send_tick(it);
   endtask

   function automatic item_type random_tick(input bit door_quiet);
      item_type it;
      int spread, t, h, m, pick, hhmm;
      pick = $urandom_range(0, 99);
      spread = clamp(int'(sb.cfg.temp_band), 0, 60) + 3;
      if (pick < 10) t = int'($urandom_range(0, 4095)) - 2048;
      else if (pick < 30) t = prev_sent_temp;
      else t = int'(sb.cfg.temp_setpoint) - spread + int'($urandom_range(0, 2 * spread));
      t = clamp(t, -2048, 2047);
      it.temp_tenths = t[TEMP_W-1:0];

      pick = $urandom_range(0, 99);
      spread = clamp(int'(sb.cfg.humid_band), 0, 60) + 3;
      if (pick < 12) h = $urandom_range(0, 1023);
      else h = int'(sb.cfg.humid_setpoint) - spread + int'($urandom_range(0, 2 * spread));
      h = clamp(h, 0, 1023);
      it.humid_tenths = h[9:0];

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         it.clock_hour   = 5'($urandom_range(0, 31));
         it.clock_minute = 6'($urandom_range(0, 63));
      end else if (pick < 55) begin
         hhmm = (pick < 35) ? int'(sb.cfg.light_start_hhmm) : int'(sb.cfg.light_stop_hhmm);
         m = (hhmm / 100) * 60 + (hhmm % 100) + int'($urandom_range(0, 2)) - 1;
         m = clamp(m, 0, 32 * 60 - 1);
         it.clock_hour   = 5'(m / 60);
         it.clock_minute = 6'(m % 60);
      end else begin
         it.clock_hour   = 5'($urandom_range(0, 23));
         it.clock_minute = 6'($urandom_range(0, 59));
      end

      it.disable_mask = ($urandom_range(0, 99) < 70) ? 4'd0 : 4'($urandom_range(0, 15));

      pick = $urandom_range(0, 99);
      if (door_quiet) it.door_event = (pick < 5) ? DOOR_UNUSED : DOOR_NONE;
      else if (pick < 2) it.door_event = DOOR_ENTER;
      else if (pick < 5) it.door_event = DOOR_LEAVE;
      else if (pick < 7) it.door_event = DOOR_UNUSED;
      else it.door_event = DOOR_NONE;
      return it;
   endfunction

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input int v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      sb.store_reg(idx, v[CSR_DATA_W-1:0]);
      @(posedge clock);
   endtask

   task automatic apply_config(input int tset, input int tband, input int hset,
                               input int hband, input int lstart, input int lstop,
                               input int frun, input int fidle);
      wait_drained();
      write_reg(REG_TEMP_SETPOINT, tset);
      write_reg(REG_TEMP_BAND, tband);
      write_reg(REG_HUMID_SETPOINT, hset);
      write_reg(REG_HUMID_BAND, hband);
      write_reg(REG_LIGHT_START_HHMM, lstart);
      write_reg(REG_LIGHT_STOP_HHMM, lstop);
      write_reg(REG_FAN_RUN_MINUTES, frun);
      write_reg(REG_FAN_IDLE_MINUTES, fidle);
      csr_we <= 1'b0;
   endtask

   function automatic int random_hhmm();
      return $urandom_range(0, 23) * 100 + $urandom_range(0, 59);
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_tick(random_tick(1'b0));
      req_tvalid <= 1'b0;
   endtask

   // response side: check each beat, then pick next ready
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_relays(result_type'(rsp_tdata[10:0]));
      if (rx_hold > 0) begin
         rx_hold    <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!rx_pressed && sb != null && sb.beats >= STALL_AFTER) begin
         rx_pressed <= 1'b1;
         rx_hold    <= STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else if ((rx_cycle % 1000) < 150) begin
         rsp_tready <= 1'b1;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:2]:   begin rx_hold <= $urandom_range(10, 50); rsp_tready <= 1'b0; end
            [3:22]:  rsp_tready <= 1'b0;
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // trend and band cases, field extremes, disables, door events
      send_fields(250, 500, 12, 0, 0, DOOR_NONE);
      send_fields(250, 500, 12, 0, 0, DOOR_NONE);
      send_fields(300, 500, 12, 1, 0, DOOR_NONE);
      send_fields(200, 500, 12, 2, 0, DOOR_NONE);
      send_fields(-400, 0, 0, 0, 0, DOOR_NONE);
      send_fields(1250, 1000, 23, 59, 0, DOOR_NONE);
      send_fields(-2048, 1023, 31, 63, 15, DOOR_NONE);
      send_fields(2047, 945, 6, 0, 0, DOOR_NONE);
      send_fields(2047, 945, 17, 59, 0, DOOR_NONE);
      send_fields(240, 960, 18, 0, 0, DOOR_NONE);
      send_fields(230, 935, 5, 59, 1, DOOR_NONE);
      send_fields(230, 935, 7, 0, 2, DOOR_NONE);
      send_fields(230, 970, 8, 0, 4, DOOR_NONE);
      send_fields(230, 970, 9, 0, 8, DOOR_NONE);
      send_fields(260, 500, 10, 0, 0, DOOR_ENTER);
      send_fields(260, 500, 10, 1, 0, DOOR_NONE);
      send_fields(260, 500, 10, 2, 0, DOOR_ENTER);
      send_fields(100, 500, 10, 3, 0, DOOR_NONE);
      send_fields(100, 500, 10, 4, 0, DOOR_LEAVE);
      send_fields(100, 500, 10, 5, 0, DOOR_LEAVE);
      send_fields(300, 500, 10, 6, 0, DOOR_UNUSED);
      send_fields(0, 0, 0, 0, 0, DOOR_NONE);
      req_tvalid <= 1'b0;

      apply_config(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(PHASE_TICKS);

      apply_config(999, 999, 999, 999, 2359, 0, 999, 999);
      run_random(PHASE_TICKS);

      apply_config(250, 10, 950, 10, 2200, 600, 1, 1);
      run_random(PHASE_TICKS / 2);
      // hold door mode until the timer runs out
      send_fields(250, 500, 1, 0, 0, DOOR_ENTER);
      repeat (DOOR_S / TICK_S + 5) send_tick(random_tick(1'b1));
      run_random(PHASE_TICKS / 2);

      apply_config(500, 5, 400, 20, 0, 2359, 2, 0);
      run_random(PHASE_TICKS);

      apply_config($urandom_range(0, 999), $urandom_range(0, 999), $urandom_range(0, 999),
                   $urandom_range(0, 999), random_hhmm(), random_hhmm(),
                   $urandom_range(0, 3), $urandom_range(0, 3));
      run_random(PHASE_TICKS);

      apply_config($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
      run_random(PHASE_TICKS);

      apply_config($urandom_range(0, 999), $urandom_range(0, 40), $urandom_range(901, 999),
                   $urandom_range(0, 40), random_hhmm(), random_hhmm(),
                   $urandom_range(1, 2), $urandom_range(0, 2));
      run_random(PHASE_TICKS);

      apply_config(int'(CFG_RESET.temp_setpoint), int'(CFG_RESET.temp_band),
                   int'(CFG_RESET.humid_setpoint), int'(CFG_RESET.humid_band),
                   int'(CFG_RESET.light_start_hhmm), int'(CFG_RESET.light_stop_hhmm),
                   1, 2);
      run_random(PHASE_TICKS);

      wait_drained();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/crc_pkg.sv
sv/crc_ctrl.sv
sv/climate_relay_controller.sv
sv/crc_checker.sv
tb/climate_relay_controller_tb.sv
